[rtl/core/ffha_pkg.sv]
// Shared types, constants and codes for the first-fit heap allocator.
// Used by the channel interfaces, the block table cells and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

   localparam int MAX_BLOCKS     = 64;
   localparam int HEADER_BYTES   = 12;
   localparam int PAGE_BYTES     = 4096;
   localparam int ALIGN_BYTES    = 16;
   localparam int MIN_GROW_PAGES = 4;

   localparam int IDX_W   = $clog2(MAX_BLOCKS);
   localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
   localparam int ADDR_W  = 32;
   localparam int BYTES_W = 29;
   localparam int NEED_W  = 30;
   localparam int AMT_W   = 31;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [ADDR_W-1:0]  HEAP_BASE_RST  = 32'h0050_0000;
   localparam logic [ADDR_W-1:0]  HEAP_TOP_RST   = 32'h1000_0000;
   localparam logic [BYTES_W-1:0] INIT_BYTES_RST = 29'h0010_0000;
   localparam logic [31:0]        OFFSET_LIMIT   = 32'h1FFF_FFFF;

   typedef enum logic [1:0] {
      KIND_INIT,
      KIND_ALLOC,
      KIND_FREE,
      KIND_REALLOC
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_HEAP_BASE,
      REG_HEAP_TOP,
      REG_INITIAL_BYTES
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_FIT,
      ST_GROW,
      ST_APPEND,
      ST_REFIT,
      ST_RELEASE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [BYTES_W-1:0] off;
      logic [BYTES_W-1:0] size;
      logic               free;
   } entry_type;

   // shift/write control broadcast along the table
   typedef struct packed {
      logic             pop;
      logic             push;
      logic [IDX_W-1:0] wpos;
      entry_type        wdata;
   } chain_ctl_type;

endpackage

`default_nettype wire

[rtl/core/ffha_if.sv]
// Valid/ready channel interfaces for allocator requests and results.
// Depends on ffha_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ffha_req_if;
   import ffha_pkg::*;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [BYTES_W-1:0] request_bytes;
   logic [ADDR_W-1:0]  block_address;

   modport source (output valid, kind, request_bytes, block_address, input ready);
   modport sink (input valid, kind, request_bytes, block_address, output ready);
endinterface

interface ffha_rsp_if;
   import ffha_pkg::*;
   logic               valid;
   logic               ready;
   logic [ADDR_W-1:0]  result_address;
   logic               ok;
   logic [BYTES_W-1:0] copy_bytes;
   logic [BYTES_W-1:0] total_bytes;
   logic [BYTES_W-1:0] used_bytes;
   logic [BYTES_W-1:0] free_bytes;

   modport source (output valid, result_address, ok, copy_bytes, total_bytes,
                   used_bytes, free_bytes, input ready);
   modport sink (input valid, result_address, ok, copy_bytes, total_bytes,
                 used_bytes, free_bytes, output ready);
endinterface

`default_nettype wire

[rtl/core/ffha_cell.sv]
// One block table entry: shifts in its right neighbor on pop, or loads the
// broadcast write data when the write position matches. Depends on ffha_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffha_cell (
   input  logic                     clock,
   input  ffha_pkg::chain_ctl_type  ctl_i,
   input  logic [ffha_pkg::IDX_W-1:0] idx_i,
   input  ffha_pkg::entry_type      nxt_i,
   output ffha_pkg::entry_type      ent_o
);
   import ffha_pkg::*;

   entry_type ent_ff;

   always_ff @(posedge clock) begin
      if (ctl_i.push && (ctl_i.wpos == idx_i)) begin
         ent_ff <= ctl_i.wdata;
      end else if (ctl_i.pop) begin
         ent_ff <= nxt_i;
      end
   end

   assign ent_o = ent_ff;

endmodule

`default_nettype wire

[rtl/core/ffha_chain.sv]
// Row of table cells acting as an ordered queue: head at cell 0, tail write
// at the broadcast position. Depends on ffha_pkg and ffha_cell.
`timescale 1ns / 1ps
`default_nettype none

module ffha_chain (
   input  logic                    clock,
   input  ffha_pkg::chain_ctl_type ctl_i,
   output ffha_pkg::entry_type     head_o
);
   import ffha_pkg::*;

   entry_type ent_w [MAX_BLOCKS];
   entry_type nxt_w [MAX_BLOCKS];

   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
      if (i == MAX_BLOCKS - 1) begin : g_last
         assign nxt_w[i] = '0;
      end else begin : g_mid
         assign nxt_w[i] = ent_w[i+1];
      end

      ffha_cell u_cell (
         .clock (clock),
         .ctl_i (ctl_i),
         .idx_i (IDX_W'(i)),
         .nxt_i (nxt_w[i]),
         .ent_o (ent_w[i])
      );
   end

   assign head_o = ent_w[0];

endmodule

`default_nettype wire

[rtl/core/first_fit_heap_allocator.sv]
// First-fit heap allocator: sequencer plus a streaming unit over the block table.
// Each table pass streams all N entries through the head unit. One request at a time;
// the next is taken as soon as the result is registered. Reset (synchronous) empties
// the table and clears the counters; the entry storage itself is not cleared and
// needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_heap_allocator (
   input  logic                              clock,
   input  logic                              reset,
   ffha_req_if.sink                          req_chan,
   ffha_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_en,
   input  logic [ffha_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ffha_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import ffha_pkg::*;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  heap_base_ff, heap_top_ff;
   logic [BYTES_W-1:0] init_bytes_ff;

   logic [CNT_W-1:0]   cnt_ff, cnt_in, rem_ff, rem_in, wr_cnt;
   logic [BYTES_W-1:0] end_ff, end_in, total_ff, total_in;
   logic [BYTES_W-1:0] used_ff, used_in, free_ff, free_in;

   kind_type           kind_ff, kind_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [NEED_W-1:0]  need_ff, need_in;
   logic [AMT_W-1:0]   amt_ff, amt_in, inc_ff, inc_in, inc_rnd;

   entry_type          acc_ff, acc_in, ext_ff, ext_in, hp, head;
   logic               acc_v_ff, acc_v_in, ext_v_ff, ext_v_in;
   logic               hit_ff, hit_in, stop_ff, stop_in, fail_ff, fail_in;
   logic               full_ff, full_in, move_ff, move_in;
   logic [BYTES_W-1:0] old_ff, old_in;

   logic [ADDR_W-1:0]  res_ff, res_in;
   logic               ok_ff, ok_in;
   logic [BYTES_W-1:0] copy_ff, copy_in;

   logic               rsp_v_ff, rsp_v_in, rsp_ok_ff, rsp_ok_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [BYTES_W-1:0] rsp_copy_ff, rsp_copy_in, rsp_total_ff, rsp_total_in;
   logic [BYTES_W-1:0] rsp_used_ff, rsp_used_in, rsp_free_ff, rsp_free_in;

   chain_ctl_type      ctl;
   logic               req_fire, in_pass, nx_pass, start, pass_done, h_v, merge;
   logic [ADDR_W-1:0]  head_pay;
   logic               head_used_hit, head_fit, head_split, acc_adj, grow_ok;
   logic [AMT_W-1:0]   split_sum;
   logic [31:0]        sum_end;
   logic [32:0]        sum_top;

   ffha_chain u_chain (
      .clock  (clock),
      .ctl_i  (ctl),
      .head_o (head)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign in_pass = (state_ff == ST_FIND) || (state_ff == ST_FIT) ||
                    (state_ff == ST_REFIT) || (state_ff == ST_RELEASE);
   assign nx_pass = (state_in == ST_FIND) || (state_in == ST_FIT) ||
                    (state_in == ST_REFIT) || (state_in == ST_RELEASE);
   assign start     = nx_pass && (state_in != state_ff);
   assign h_v       = (rem_ff != '0);
   assign pass_done = in_pass && !h_v && !acc_v_ff && !ext_v_ff;

   assign head_pay      = heap_base_ff + ADDR_W'(head.off) + ADDR_W'(HEADER_BYTES);
   assign head_used_hit = !head.free && (head_pay == addr_ff);
   assign head_fit      = head.free && (NEED_W'(head.size) >= need_ff);
   assign head_split    = AMT_W'(head.size) >=
                          (AMT_W'(need_ff) + AMT_W'(HEADER_BYTES + ALIGN_BYTES));
   assign split_sum     = AMT_W'(head.off) + AMT_W'(HEADER_BYTES) + AMT_W'(need_ff);
   // blocks merge only when they touch
   assign acc_adj = (AMT_W'(acc_ff.off) + AMT_W'(acc_ff.size) + AMT_W'(HEADER_BYTES))
                    == AMT_W'(head.off);

   assign inc_rnd = (amt_ff + AMT_W'(PAGE_BYTES - 1)) & ~AMT_W'(PAGE_BYTES - 1);
   assign sum_end = 32'(end_ff) + 32'(inc_ff);
   assign sum_top = 33'(heap_base_ff) + 33'(sum_end);
   assign grow_ok = (cnt_ff < CNT_W'(MAX_BLOCKS)) && (sum_top <= 33'(heap_top_ff)) &&
                    (sum_end <= OFFSET_LIMIT);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (kind_type'(req_chan.kind))
                  KIND_INIT:  state_in = ST_GROW;
                  KIND_ALLOC: state_in = (req_chan.request_bytes == '0) ? ST_RESP : ST_FIT;
                  KIND_FREE:  state_in = (req_chan.block_address == '0) ? ST_RESP : ST_FIND;
                  KIND_REALLOC: begin
                     if (req_chan.block_address != '0) begin
                        state_in = ST_FIND;
                     end else begin
                        state_in = (req_chan.request_bytes == '0) ? ST_RESP : ST_FIT;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_FIND: begin
            if (pass_done) begin
               if (!hit_ff) begin
                  state_in = ST_RESP;
               end else if (kind_ff == KIND_FREE || bytes_ff == '0) begin
                  state_in = ST_RELEASE;
               end else if (old_ff >= bytes_ff) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_FIT;
               end
            end
         end
         ST_FIT: begin
            if (pass_done) begin
               if (hit_ff) begin
                  state_in = move_ff ? ST_RELEASE : ST_RESP;
               end else begin
                  state_in = fail_ff ? ST_RESP : ST_GROW;
               end
            end
         end
         ST_GROW:   state_in = ST_APPEND;
         ST_APPEND: begin
            if (grow_ok && kind_ff != KIND_INIT) begin
               state_in = ST_REFIT;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_REFIT: begin
            if (pass_done) begin
               state_in = (hit_ff && move_ff) ? ST_RELEASE : ST_RESP;
            end
         end
         ST_RELEASE: begin
            if (pass_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_v_ff || rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and table control
   always_comb begin
      kind_in = kind_ff;   bytes_in = bytes_ff; addr_in = addr_ff;
      need_in = need_ff;   amt_in = amt_ff;     inc_in = inc_ff;
      rem_in = rem_ff;     acc_in = acc_ff;     acc_v_in = acc_v_ff;
      ext_in = ext_ff;     ext_v_in = ext_v_ff;
      hit_in = hit_ff;     stop_in = stop_ff;   fail_in = fail_ff;
      full_in = full_ff;   move_in = move_ff;   old_in = old_ff;
      res_in = res_ff;     ok_in = ok_ff;       copy_in = copy_ff;
      end_in = end_ff;     total_in = total_ff; used_in = used_ff; free_in = free_ff;
      rsp_v_in = rsp_v_ff; rsp_ok_in = rsp_ok_ff; rsp_addr_in = rsp_addr_ff;
      rsp_copy_in = rsp_copy_ff; rsp_total_in = rsp_total_ff;
      rsp_used_in = rsp_used_ff; rsp_free_in = rsp_free_ff;
      ctl = '0;
      ctl.wdata = acc_ff;
      hp = head;
      merge = 1'b0;

      if (rsp_v_ff && rsp_chan.ready) begin
         rsp_v_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in  = kind_type'(req_chan.kind);
               bytes_in = req_chan.request_bytes;
               addr_in  = req_chan.block_address;
               need_in  = (NEED_W'(req_chan.request_bytes) + NEED_W'(ALIGN_BYTES - 1)) &
                          ~NEED_W'(ALIGN_BYTES - 1);
               amt_in   = AMT_W'(init_bytes_ff);
               res_in   = '0;
               ok_in    = 1'b1;
               copy_in  = '0;
               move_in  = 1'b0;
            end
         end
         ST_FIND, ST_FIT, ST_REFIT, ST_RELEASE: begin
            if (ext_v_ff) begin
               // second half of a split goes out one item late
               ctl.push = 1'b1;
               acc_in   = ext_ff;
               ext_v_in = 1'b0;
            end else if (h_v) begin
               ctl.pop = 1'b1;
               rem_in  = rem_ff - 1'b1;
               if (state_ff == ST_FIND) begin
                  if (!hit_ff && head_used_hit) begin
                     hit_in = 1'b1;
                     old_in = head.size;
                  end
               end else if (state_ff == ST_RELEASE) begin
                  if (!hit_ff && head_used_hit) begin
                     hp.free = 1'b1;
                     used_in = used_ff - head.size;
                     free_in = free_ff + head.size;
                     hit_in  = 1'b1;
                  end
                  merge = acc_v_ff && acc_ff.free && hp.free && acc_adj;
               end else begin
                  if (!stop_ff && head_fit) begin
                     stop_in = 1'b1;
                     if (head_split && full_ff) begin
                        fail_in = 1'b1;
                     end else begin
                        hit_in  = 1'b1;
                        res_in  = head_pay;
                        hp.free = 1'b0;
                        if (head_split) begin
                           hp.size     = need_ff[BYTES_W-1:0];
                           ext_in.off  = split_sum[BYTES_W-1:0];
                           ext_in.size = head.size - need_ff[BYTES_W-1:0] -
                                         BYTES_W'(HEADER_BYTES);
                           ext_in.free = 1'b1;
                           ext_v_in    = 1'b1;
                           free_in     = free_ff - need_ff[BYTES_W-1:0] -
                                         BYTES_W'(HEADER_BYTES);
                           used_in     = used_ff + need_ff[BYTES_W-1:0];
                        end else begin
                           free_in = free_ff - head.size;
                           used_in = used_ff + head.size;
                        end
                     end
                  end
               end
               if (merge) begin
                  acc_in.size = acc_ff.size + BYTES_W'(HEADER_BYTES) + hp.size;
               end else begin
                  ctl.push = acc_v_ff;
                  acc_in   = hp;
                  acc_v_in = 1'b1;
               end
            end else if (acc_v_ff) begin
               ctl.push = 1'b1;
               acc_v_in = 1'b0;
            end

            if (pass_done) begin
               if (state_ff == ST_FIND) begin
                  if (!hit_ff) begin
                     ok_in = 1'b0;
                  end else if (kind_ff == KIND_REALLOC && bytes_ff != '0) begin
                     if (old_ff >= bytes_ff) begin
                        res_in = addr_ff;
                     end else begin
                        move_in = 1'b1;
                     end
                  end
               end else if (state_ff != ST_RELEASE) begin
                  if (hit_ff) begin
                     if (move_ff) begin
                        copy_in = old_ff;
                     end
                  end else if (state_ff == ST_FIT && !fail_ff) begin
                     amt_in = AMT_W'(need_ff) + AMT_W'(HEADER_BYTES);
                  end else begin
                     ok_in = 1'b0;
                  end
               end
            end
         end
         ST_GROW: begin
            if (kind_ff != KIND_INIT &&
                inc_rnd < AMT_W'(PAGE_BYTES * MIN_GROW_PAGES)) begin
               inc_in = AMT_W'(PAGE_BYTES * MIN_GROW_PAGES);
            end else if (inc_rnd == '0) begin
               inc_in = AMT_W'(PAGE_BYTES);
            end else begin
               inc_in = inc_rnd;
            end
         end
         ST_APPEND: begin
            if (grow_ok) begin
               ctl.push       = 1'b1;
               ctl.wdata.off  = end_ff;
               ctl.wdata.size = inc_ff[BYTES_W-1:0] - BYTES_W'(HEADER_BYTES);
               ctl.wdata.free = 1'b1;
               end_in   = end_ff + inc_ff[BYTES_W-1:0];
               total_in = total_ff + inc_ff[BYTES_W-1:0] - BYTES_W'(HEADER_BYTES);
               free_in  = free_ff + inc_ff[BYTES_W-1:0] - BYTES_W'(HEADER_BYTES);
            end else begin
               ok_in = 1'b0;
            end
         end
         ST_RESP: begin
            if (!rsp_v_ff || rsp_chan.ready) begin
               rsp_v_in     = 1'b1;
               rsp_addr_in  = res_ff;
               rsp_ok_in    = ok_ff;
               rsp_copy_in  = copy_ff;
               rsp_total_in = total_ff;
               rsp_used_in  = used_ff;
               rsp_free_in  = free_ff;
            end
         end
         default: begin
         end
      endcase

      wr_cnt   = cnt_ff - CNT_W'(ctl.pop);
      ctl.wpos = wr_cnt[IDX_W-1:0];
      cnt_in   = wr_cnt + CNT_W'(ctl.push);

      if (start) begin
         rem_in   = cnt_in;
         acc_v_in = 1'b0;
         ext_v_in = 1'b0;
         hit_in   = 1'b0;
         stop_in  = 1'b0;
         fail_in  = 1'b0;
         full_in  = (cnt_in == CNT_W'(MAX_BLOCKS));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         heap_base_ff  <= HEAP_BASE_RST;
         heap_top_ff   <= HEAP_TOP_RST;
         init_bytes_ff <= INIT_BYTES_RST;
         cnt_ff        <= '0;
         rem_ff        <= '0;
         end_ff        <= '0;
         total_ff      <= '0;
         used_ff       <= '0;
         free_ff       <= '0;
         acc_v_ff      <= 1'b0;
         ext_v_ff      <= 1'b0;
         hit_ff        <= 1'b0;
         stop_ff       <= 1'b0;
         fail_ff       <= 1'b0;
         full_ff       <= 1'b0;
         move_ff       <= 1'b0;
         rsp_v_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rem_ff   <= rem_in;
         end_ff   <= end_in;
         total_ff <= total_in;
         used_ff  <= used_in;
         free_ff  <= free_in;
         acc_v_ff <= acc_v_in;
         ext_v_ff <= ext_v_in;
         hit_ff   <= hit_in;
         stop_ff  <= stop_in;
         fail_ff  <= fail_in;
         full_ff  <= full_in;
         move_ff  <= move_in;
         rsp_v_ff <= rsp_v_in;
         if (csr_write_en) begin
            case (csr_index)
               REG_HEAP_BASE:     heap_base_ff  <= csr_write_data;
               REG_HEAP_TOP:      heap_top_ff   <= csr_write_data;
               REG_INITIAL_BYTES: init_bytes_ff <= csr_write_data[BYTES_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      bytes_ff     <= bytes_in;
      addr_ff      <= addr_in;
      need_ff      <= need_in;
      amt_ff       <= amt_in;
      inc_ff       <= inc_in;
      acc_ff       <= acc_in;
      ext_ff       <= ext_in;
      old_ff       <= old_in;
      res_ff       <= res_in;
      ok_ff        <= ok_in;
      copy_ff      <= copy_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_copy_ff  <= rsp_copy_in;
      rsp_total_ff <= rsp_total_in;
      rsp_used_ff  <= rsp_used_in;
      rsp_free_ff  <= rsp_free_in;
   end

   assign rsp_chan.valid          = rsp_v_ff;
   assign rsp_chan.result_address = rsp_addr_ff;
   assign rsp_chan.ok             = rsp_ok_ff;
   assign rsp_chan.copy_bytes     = rsp_copy_ff;
   assign rsp_chan.total_bytes    = rsp_total_ff;
   assign rsp_chan.used_bytes     = rsp_used_ff;
   assign rsp_chan.free_bytes     = rsp_free_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_BLOCKS))
      else $error("block count above table depth");

   a_ext_has_acc: assert property (@(posedge clock) disable iff (reset)
      ext_v_ff |-> (acc_v_ff && in_pass))
      else $error("split remainder pending without its head part");

   a_acc_in_pass: assert property (@(posedge clock) disable iff (reset)
      !in_pass |-> (!acc_v_ff && !ext_v_ff))
      else $error("stream unit holds an entry outside a pass");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (rem_ff == '0))
      else $error("pass left entries unvisited");

   a_append_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPEND && grow_ok) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("heap growth did not add a block");

endmodule

`default_nettype wire
